### rtl/core/battery_soc_interp_ema_unit_assert.svh
// ----------------------------------------------------------------------------
// battery_soc_interp_ema_unit_assert
// assertion macros shared by the battery state of charge logic
// ----------------------------------------------------------------------------
`ifndef BATTERY_SOC_INTERP_EMA_UNIT_ASSERT_SVH
`define BATTERY_SOC_INTERP_EMA_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define BSOC_ASSERT_IMP(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("bsoc assertion failed");

// next-cycle implication, sampled on clk, off during rst
`define BSOC_ASSERT_NXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("bsoc assertion failed");

`endif

### rtl/core/bsoc_pkg.sv
// ----------------------------------------------------------------------------
// bsoc_pkg
// voltage to charge table and fixed constants for the state of charge unit
// ----------------------------------------------------------------------------
package bsoc_pkg;

  // table rom depth and index width
  localparam int unsigned ROM_SIZE = 32;
  localparam int unsigned IDX_W    = 5;

  // fixed point widths
  localparam int unsigned MV_W     = 16;
  localparam int unsigned SOC_W    = 7;
  localparam int unsigned Q_W      = 23;
  localparam int unsigned ALPHA_W  = 16;
  localparam int unsigned MUL_A_W  = 17;
  localparam int unsigned PROD_W   = 40;

  // filter weight after reset, about 0.1 in q0.16
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd6554;

  // 16s lifepo4 pack curve, padded with the last point
  localparam logic [MV_W-1:0] TABLE_MV [ROM_SIZE] = '{
    16'd40000, 16'd44000, 16'd46400, 16'd48000, 16'd49600, 16'd50400,
    16'd51200, 16'd51600, 16'd52000, 16'd52800, 16'd53600, 16'd54400,
    16'd55200, 16'd55200, 16'd55200, 16'd55200, 16'd55200, 16'd55200,
    16'd55200, 16'd55200, 16'd55200, 16'd55200, 16'd55200, 16'd55200,
    16'd55200, 16'd55200, 16'd55200, 16'd55200, 16'd55200, 16'd55200,
    16'd55200, 16'd55200
  };

  localparam logic [SOC_W-1:0] TABLE_SOC [ROM_SIZE] = '{
    7'd0,   7'd5,   7'd10,  7'd20,  7'd30,  7'd40,  7'd50,  7'd60,
    7'd70,  7'd80,  7'd90,  7'd95,  7'd100, 7'd100, 7'd100, 7'd100,
    7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100,
    7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100
  };

  // full scale charge, 100 percent in q7.16
  localparam logic [Q_W-1:0] Q_FULL = 23'd6553600;

endpackage

### rtl/core/battery_soc_interp_ema_unit.sv
// ----------------------------------------------------------------------------
// battery_soc_interp_ema_unit
// pack voltage to filtered state of charge in percent
// ----------------------------------------------------------------------------
// One voltage sample in, one charge percentage out. A sample outside the table
// goes from the clamp step straight to the filter. For a sample inside the
// table, a compare per cycle walks the table to find the segment, a restoring
// divider forms the slope term, and one shared 17x23 multiplier serves the
// slope product and both filter products. The unit works on one sample at a
// time: in_stall stays high while a sample is being worked on; a finished
// result sits in the output register, so the next sample may be taken while
// it waits. The first sample after reset loads the filter directly. smoothing
// alpha is written through the cfg port; the user must write it only while
// idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "battery_soc_interp_ema_unit_assert.svh"

module battery_soc_interp_ema_unit #(
  parameter int unsigned TABLE_POINTS = 13
) (
  input  logic                         clk,
  input  logic                         rst,
  // sample channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [bsoc_pkg::MV_W-1:0]    battery_mv,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [bsoc_pkg::SOC_W-1:0]   charge_percent,
  // filter weight write
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bsoc_pkg::ALPHA_W-1:0] cfg_data
);

  localparam logic [bsoc_pkg::IDX_W-1:0] LAST_IDX = bsoc_pkg::IDX_W'(TABLE_POINTS - 1);

  // sequencer states
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_CLAMP   = 4'd1;
  localparam logic [3:0] S_SEARCH  = 4'd2;
  localparam logic [3:0] S_MUL     = 4'd3;
  localparam logic [3:0] S_DIVPREP = 4'd4;
  localparam logic [3:0] S_DIV     = 4'd5;
  localparam logic [3:0] S_RAW     = 4'd6;
  localparam logic [3:0] S_FILT    = 4'd7;
  localparam logic [3:0] S_EMA2    = 4'd8;
  localparam logic [3:0] S_EMA3    = 4'd9;
  localparam logic [3:0] S_OUT     = 4'd10;

  localparam logic [4:0] DIV_LAST  = 5'd22;

  logic [3:0]                      state;
  logic [bsoc_pkg::MV_W-1:0]       volt;
  logic [bsoc_pkg::IDX_W-1:0]      idx;
  logic [bsoc_pkg::PROD_W-1:0]     prod;
  logic [bsoc_pkg::PROD_W-1:0]     acc;
  logic [bsoc_pkg::MV_W-1:0]       rem;
  logic [bsoc_pkg::Q_W-1:0]        dq;
  logic [4:0]                      cnt;
  logic [bsoc_pkg::MV_W-1:0]       dwidth;
  logic [bsoc_pkg::Q_W-1:0]        raw;
  logic [bsoc_pkg::Q_W-1:0]        filtered_charge;
  logic                            filter_loaded;
  logic [bsoc_pkg::ALPHA_W-1:0]    alpha;

  logic [bsoc_pkg::IDX_W-1:0]      idx_hi;
  logic [bsoc_pkg::MV_W-1:0]       seg_lo;
  logic [bsoc_pkg::MV_W-1:0]       seg_hi;
  logic [bsoc_pkg::MV_W-1:0]       seg_width;
  logic [bsoc_pkg::SOC_W-1:0]      soc_lo;
  logic [bsoc_pkg::SOC_W-1:0]      rise;
  logic [bsoc_pkg::MUL_A_W-1:0]    mul_a;
  logic [bsoc_pkg::Q_W-1:0]        mul_b;
  logic [bsoc_pkg::PROD_W-1:0]     mul_p;
  logic [bsoc_pkg::MV_W:0]         div_r2;
  logic [bsoc_pkg::MV_W:0]         div_w;
  logic                            div_ge;
  logic [bsoc_pkg::PROD_W:0]       ema_sum;
  logic [bsoc_pkg::Q_W:0]          round_sum;
  logic                            out_free;

  // handshakes
  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;

  // segment endpoints from the rom
  assign idx_hi    = idx + 1'b1;
  assign seg_lo    = bsoc_pkg::TABLE_MV[idx];
  assign seg_hi    = bsoc_pkg::TABLE_MV[idx_hi];
  assign seg_width = seg_hi - seg_lo;
  assign soc_lo    = bsoc_pkg::TABLE_SOC[idx];
  assign rise      = bsoc_pkg::TABLE_SOC[idx_hi] - soc_lo;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_MUL: begin
        mul_a = {1'b0, volt - seg_lo};
        mul_b = bsoc_pkg::Q_W'(rise);
      end
      S_FILT: begin
        mul_a = {1'b0, alpha};
        mul_b = raw;
      end
      S_EMA2: begin
        mul_a = 17'h10000 - {1'b0, alpha};
        mul_b = filtered_charge;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = bsoc_pkg::PROD_W'(mul_a) * bsoc_pkg::PROD_W'(mul_b);

  // one restoring divide step
  assign div_r2 = {rem, dq[bsoc_pkg::Q_W-1]};
  assign div_w  = {1'b0, dwidth};
  assign div_ge = (div_r2 >= div_w);

  // filter sum and output rounding
  assign ema_sum   = {1'b0, acc} + {1'b0, prod} + 41'd32768;
  assign round_sum = {1'b0, filtered_charge} + 24'd32768;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha <= bsoc_pkg::ALPHA_RESET;
    end else if (cfg_valid && cfg_ready) begin
      alpha <= cfg_data;
    end
  end

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      filter_loaded   <= 1'b0;
      filtered_charge <= '0;
      out_valid       <= 1'b0;
    end else begin
      // result transfer, unless a new result is loaded in the same cycle
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            volt  <= battery_mv;
            state <= S_CLAMP;
          end
        end
        // clamp to the table ends
        S_CLAMP: begin
          idx <= '0;
          if (volt <= bsoc_pkg::TABLE_MV[0]) begin
            raw   <= {bsoc_pkg::TABLE_SOC[0], 16'h0000};
            state <= S_FILT;
          end else if (volt >= bsoc_pkg::TABLE_MV[LAST_IDX]) begin
            raw   <= {bsoc_pkg::TABLE_SOC[LAST_IDX], 16'h0000};
            state <= S_FILT;
          end else begin
            state <= S_SEARCH;
          end
        end
        // walk the table one segment per cycle
        S_SEARCH: begin
          if (volt <= seg_hi || idx_hi == LAST_IDX) begin
            state <= S_MUL;
          end else begin
            idx <= idx_hi;
          end
        end
        // offset times charge rise
        S_MUL: begin
          prod   <= mul_p;
          dwidth <= seg_width;
          if (seg_width == '0) begin
            raw   <= {soc_lo, 16'h0000};
            state <= S_FILT;
          end else begin
            state <= S_DIVPREP;
          end
        end
        // dividend is product * 65536 plus half the width
        S_DIVPREP: begin
          rem   <= prod[22:7];
          dq    <= {prod[6:0], 1'b0, dwidth[15:1]};
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem <= div_ge ? bsoc_pkg::MV_W'(div_r2 - div_w) : div_r2[bsoc_pkg::MV_W-1:0];
          dq  <= {dq[bsoc_pkg::Q_W-2:0], div_ge};
          cnt <= cnt + 1'b1;
          if (cnt == DIV_LAST) begin
            state <= S_RAW;
          end
        end
        S_RAW: begin
          raw   <= {soc_lo, 16'h0000} + dq;
          state <= S_FILT;
        end
        // load the filter or start the weighted sum
        S_FILT: begin
          if (!filter_loaded) begin
            filtered_charge <= raw;
            filter_loaded   <= 1'b1;
            state           <= S_OUT;
          end else begin
            prod  <= mul_p;
            state <= S_EMA2;
          end
        end
        S_EMA2: begin
          acc   <= prod;
          prod  <= mul_p;
          state <= S_EMA3;
        end
        S_EMA3: begin
          filtered_charge <= ema_sum[38:16];
          state           <= S_OUT;
        end
        // hand the rounded charge to the output register
        S_OUT: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            charge_percent <= round_sum[22:16];
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  `BSOC_ASSERT_IMP(a_div_rem_below_width, state == S_DIV, rem < dwidth)
  `BSOC_ASSERT_IMP(a_filter_in_range, 1'b1, filtered_charge <= bsoc_pkg::Q_FULL)
  `BSOC_ASSERT_IMP(a_result_in_range, out_valid, charge_percent <= 7'd100)
  `BSOC_ASSERT_NXT(a_result_after_load, state == S_OUT && out_free, filter_loaded && out_valid)
  `BSOC_ASSERT_IMP(a_raw_in_range, state == S_FILT, raw <= bsoc_pkg::Q_FULL)

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the pack voltage to state of charge unit: a local
// table interpolator and exponential moving-average filter predict every
// charge value, while directed and random samples run under several idle/stall
// mixes and filter weights
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // 16s lifepo4 curve as the bench sees it, 13 knots
  localparam int unsigned KNOTS = 13;
  localparam logic [15:0] KNOT_MV [KNOTS] = '{
    16'd40000, 16'd44000, 16'd46400, 16'd48000, 16'd49600, 16'd50400,
    16'd51200, 16'd51600, 16'd52000, 16'd52800, 16'd53600, 16'd54400,
    16'd55200
  };
  localparam logic [6:0] KNOT_SOC [KNOTS] = '{
    7'd0, 7'd5, 7'd10, 7'd20, 7'd30, 7'd40, 7'd50, 7'd60,
    7'd70, 7'd80, 7'd90, 7'd95, 7'd100
  };

  localparam logic [15:0] ALPHA_AT_RESET = 16'd6554;
  localparam int unsigned STALL_LIMIT    = 4000;
  localparam int unsigned SETTLE_CYCLES  = 100;
  localparam int unsigned MAX_REPORTS    = 20;

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           in_valid;
  logic                           in_stall;
  logic [bsoc_pkg::MV_W-1:0]      battery_mv;
  logic                           out_valid;
  logic                           out_stall;
  logic [bsoc_pkg::SOC_W-1:0]     charge_percent;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [bsoc_pkg::ALPHA_W-1:0]   cfg_data;

  // predictor state
  logic [15:0]          model_weight;
  logic [22:0]          ema_charge;
  logic                 ema_loaded;
  logic [6:0]           expected_percent [$];

  int unsigned          error_count;
  int unsigned          send_idle_pct;
  int unsigned          recv_stall_pct;
  int unsigned          quiet_cycles;

  battery_soc_interp_ema_unit u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .battery_mv     (battery_mv),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .charge_percent (charge_percent),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // unfiltered charge in q7.16 from the knot table
  function automatic logic [22:0] charge_q16_from_mv(input logic [15:0] mv);
    int unsigned seg;
    logic [63:0] span;
    logic [63:0] num;
    seg = 0;
    if (mv <= KNOT_MV[0]) return {KNOT_SOC[0], 16'd0};
    if (mv >= KNOT_MV[KNOTS-1]) return {KNOT_SOC[KNOTS-1], 16'd0};
    for (int k = 0; k < KNOTS - 1; k++)
      if (mv > KNOT_MV[k]) seg = k;
    span = 64'(KNOT_MV[seg+1] - KNOT_MV[seg]);
    if (span == 0) return {KNOT_SOC[seg], 16'd0};
    num = 64'(mv - KNOT_MV[seg]) * 64'(KNOT_SOC[seg+1] - KNOT_SOC[seg]) * 64'd65536;
    return {KNOT_SOC[seg], 16'd0} + 23'((num + span / 2) / span);
  endfunction

  // advance the filter by one sample, give the rounded percent
  function automatic logic [6:0] filter_step_percent(input logic [15:0] mv);
    logic [22:0] raw;
    logic [63:0] acc;
    logic [31:0] rounded;
    raw = charge_q16_from_mv(mv);
    if (!ema_loaded) begin
      ema_charge = raw;
      ema_loaded = 1'b1;
    end else begin
      acc = 64'(model_weight) * 64'(raw)
            + (64'd65536 - 64'(model_weight)) * 64'(ema_charge) + 64'd32768;
      ema_charge = acc[38:16];
    end
    rounded = (32'(ema_charge) + 32'd32768) >> 16;
    return rounded[6:0];
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (error_count < MAX_REPORTS)
      $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // one sample transfer, valid held until accepted
  task automatic send_sample(input logic [15:0] mv);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    battery_mv <= mv;
    do @(posedge clk); while (in_stall);
    expected_percent.push_back(filter_step_percent(mv));
  endtask

  // drop valid and wait for every pending result
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_percent.size() != 0) @(posedge clk);
  endtask

  // filter weight write, only with the unit idle
  task automatic set_alpha(input logic [15:0] alpha);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= alpha;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    model_weight = alpha;
  endtask

  // mostly inside the curve, some near knots, some anywhere
  function automatic logic [15:0] pick_mv();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 70) return 16'($urandom_range(57000, 38000));
    if (sel < 85) return KNOT_MV[$urandom_range(KNOTS-1)] + 16'($urandom_range(2)) - 16'd1;
    return 16'($urandom_range(65535));
  endfunction

  // first sample loads the filter, then clamping at both ends
  task automatic test_first_sample_and_clamp();
    send_sample(16'd47000);
    send_sample(16'd0);
    send_sample(16'd65535);
    send_sample(16'd39999);
    send_sample(16'd40000);
    send_sample(16'd55200);
    send_sample(16'd55201);
  endtask

  // near-unity weight so each knot and segment edge shows through
  task automatic test_table_knots();
    set_alpha(16'd65535);
    send_sample(16'd40001);
    for (int k = 1; k < KNOTS - 1; k++) send_sample(KNOT_MV[k]);
    send_sample(16'd55199);
    send_sample(16'd42000);
  endtask

  // zero weight: filter holds whatever it has
  task automatic test_alpha_zero_hold();
    set_alpha(16'd0);
    send_sample(16'd40000);
    send_sample(16'd65535);
    send_sample(16'd50000);
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
                                     input logic [15:0] alpha, input int unsigned count);
    set_alpha(alpha);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_sample(pick_mv());
  endtask

  // sender holds off until the unit has emptied, now and then
  task automatic test_pause_until_drained();
    send_idle_pct  = 0;
    recv_stall_pct = 33;
    for (int n = 0; n < 30; n++) begin
      if (n % 5 == 4) wait_drained();
      send_sample(pick_mv());
    end
  endtask

  initial begin
    rst            <= 1'b1;
    in_valid       <= 1'b0;
    battery_mv     <= '0;
    out_stall      <= 1'b0;
    cfg_valid      <= 1'b0;
    cfg_data       <= '0;
    model_weight   = ALPHA_AT_RESET;
    ema_charge     = '0;
    ema_loaded     = 1'b0;
    error_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_first_sample_and_clamp();
    test_table_knots();
    test_alpha_zero_hold();
    test_random_traffic(0, 0, 16'd65535, 200);
    test_random_traffic(57, 0, 16'd1, 200);
    test_random_traffic(0, 57, 16'($urandom_range(65535, 1)), 200);
    test_random_traffic(33, 33, ALPHA_AT_RESET, 200);
    test_pause_until_drained();
    test_random_traffic(57, 57, 16'($urandom_range(65535, 1)), 200);

    // let everything drain and settle
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("** battery_soc_interp_ema_unit: PASSED **");
    end else begin
      $display("** battery_soc_interp_ema_unit: FAILED **");
    end
    $finish;
  end

  // result check and receiver stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_percent.size() == 0) begin
        report_mismatch("unexpected charge_percent", charge_percent, -1);
      end else begin
        if (charge_percent !== expected_percent[0])
          report_mismatch("charge_percent", charge_percent, expected_percent[0]);
        void'(expected_percent.pop_front());
      end
    end
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("** battery_soc_interp_ema_unit: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
